/* rtl/dad_pkg.sv */
// shared types, constants and helpers for the date adder
package dad_pkg;

    localparam int DAD_ADD_BITS = 16;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int DAYS_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [YEAR_W-1:0]  MAX_YEAR    = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] LAST_MONTH  = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] FIRST_MONTH = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   FIRST_DAY   = DAY_W'(1);

    // gregorian cycle and the century marks inside it
    localparam int LEAP_CYCLE   = 400;
    localparam int CENTURY      = 100;
    localparam int REDUCE_STEPS = 6;

    localparam logic [YEAR_W-1:0] REF_YEAR_RST  = YEAR_W'(2023);
    localparam logic [MONTH_W-1:0] REF_MONTH_RST = MONTH_W'(6);
    localparam logic [DAY_W-1:0]  REF_DAY_RST   = DAY_W'(13);

    localparam logic [CFG_IDX_W-1:0] REG_REF_YEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DAY   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic walk;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic reduce_last;
        logic date_ok;
        logic walk_done;
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4:    len = DAY_W'(30);
            4'd6:    len = DAY_W'(30);
            4'd9:    len = DAY_W'(30);
            4'd11:   len = DAY_W'(30);
            default: len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

/* rtl/dad_if.sv */
// valid/ready channel interfaces for requests and results
interface dad_in_if import dad_pkg::*;;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [DAYS_W-1:0]  days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                    output ready);
endinterface

interface dad_out_if import dad_pkg::*;;
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   end_year;
    logic [MONTH_W-1:0]  end_month;
    logic [DAY_W-1:0]    end_day;
    logic                after_reference;
    logic [STATUS_W-1:0] status;

    modport source (output valid, end_year, end_month, end_day, after_reference, status,
                    input ready);
    modport sink   (input valid, end_year, end_month, end_day, after_reference, status,
                    output ready);
endinterface

/* rtl/dad_ctrl.sv */
// sequencer for load, year reduction, check, month walk and result hand-off
module dad_ctrl import dad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_CHECK  = 5'b00100,
        S_WALK   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.date_ok ? S_WALK : S_EMIT;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/dad_dp.sv */
// date registers, leap tracking, month step and result registers
module dad_dp import dad_pkg::*; #(
    parameter int ADD_BITS = DAD_ADD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [YEAR_W-1:0]     i_start_year,
    input  logic [MONTH_W-1:0]    i_start_month,
    input  logic [DAY_W-1:0]      i_start_day,
    input  logic [DAYS_W-1:0]     i_days_to_add,
    output logic [YEAR_W-1:0]     o_end_year,
    output logic [MONTH_W-1:0]    o_end_month,
    output logic [DAY_W-1:0]      o_end_day,
    output logic                  o_after_reference,
    output logic [STATUS_W-1:0]   o_status
);

    // only bits present on the input field can count
    localparam int CNT_W = (ADD_BITS < DAYS_W) ? ADD_BITS : DAYS_W;
    localparam int K_W   = $clog2(REDUCE_STEPS);
    localparam int LEFT_W = DAY_W + 1;

    logic [YEAR_W-1:0]   r_ref_year;
    logic [MONTH_W-1:0]  r_ref_month;
    logic [DAY_W-1:0]    r_ref_day;

    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [CNT_W-1:0]    r_add;
    logic [YEAR_W-1:0]   r_rem;     // year mod 400 once reduced
    logic [K_W-1:0]      r_k;
    t_status             r_status;

    logic [YEAR_W-1:0]   r_out_year;
    logic [MONTH_W-1:0]  r_out_month;
    logic [DAY_W-1:0]    r_out_day;
    logic                r_out_after;
    t_status             r_out_status;

    logic [YEAR_W-1:0]   w_sub;
    logic                w_leap;
    logic [DAY_W-1:0]    w_dim;
    logic [LEFT_W-1:0]   w_left;
    logic                w_fits;
    logic                w_last_year;
    logic                w_after;

    assign w_sub  = YEAR_W'(LEAP_CYCLE) << r_k;
    assign w_leap = (r_year[1:0] == 2'b00)
                 && (r_rem != YEAR_W'(CENTURY))
                 && (r_rem != YEAR_W'(2 * CENTURY))
                 && (r_rem != YEAR_W'(3 * CENTURY));
    assign w_dim  = days_in(r_month, w_leap);
    assign w_left = LEFT_W'(w_dim) - LEFT_W'(r_day) + LEFT_W'(1);
    assign w_fits = r_add < CNT_W'(w_left);
    assign w_last_year = (r_month == LAST_MONTH) && (r_year >= MAX_YEAR);

    assign o_sts.reduce_last = (r_k == '0);
    assign o_sts.date_ok     = (r_year != '0) && (r_year <= MAX_YEAR)
                            && (r_month != '0) && (r_month <= LAST_MONTH)
                            && (r_day != '0) && (r_day <= w_dim);
    assign o_sts.walk_done   = w_fits || w_last_year;

    always_comb begin
        if (r_year != r_ref_year) begin
            w_after = r_year > r_ref_year;
        end else if (r_month != r_ref_month) begin
            w_after = r_month > r_ref_month;
        end else begin
            w_after = r_day > r_ref_day;
        end
    end

    // reference registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_year  <= REF_YEAR_RST;
            r_ref_month <= REF_MONTH_RST;
            r_ref_day   <= REF_DAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REF_YEAR:  r_ref_year  <= i_cfg_data[YEAR_W-1:0];
                REG_REF_MONTH: r_ref_month <= i_cfg_data[MONTH_W-1:0];
                REG_REF_DAY:   r_ref_day   <= i_cfg_data[DAY_W-1:0];
                default: ;
            endcase
        end
    end

    // working date
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= i_start_year;
            r_month  <= i_start_month;
            r_day    <= i_start_day;
            r_add    <= i_days_to_add[CNT_W-1:0];
            r_rem    <= i_start_year;
            r_k      <= K_W'(REDUCE_STEPS - 1);
            r_status <= ST_OK;
        end else if (i_cmd.reduce) begin
            // restoring reduction by 400 times a power of two
            if (r_rem >= w_sub) begin
                r_rem <= r_rem - w_sub;
            end
            if (r_k != '0) begin
                r_k <= r_k - K_W'(1);
            end
        end else if (i_cmd.check) begin
            if (!o_sts.date_ok) begin
                r_status <= ST_INVALID;
            end
        end else if (i_cmd.walk) begin
            if (w_fits) begin
                r_day <= r_day + r_add[DAY_W-1:0];
            end else begin
                r_add <= r_add - CNT_W'(w_left);
                r_day <= FIRST_DAY;
                if (r_month == LAST_MONTH) begin
                    if (r_year >= MAX_YEAR) begin
                        r_status <= ST_OVERFLOW;
                    end else begin
                        r_year  <= r_year + YEAR_W'(1);
                        r_month <= FIRST_MONTH;
                        r_rem   <= (r_rem == YEAR_W'(LEAP_CYCLE - 1)) ? '0
                                                                      : r_rem + YEAR_W'(1);
                    end
                end else begin
                    r_month <= r_month + MONTH_W'(1);
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_status == ST_OK) begin
                r_out_year  <= r_year;
                r_out_month <= r_month;
                r_out_day   <= r_day;
                r_out_after <= w_after;
            end else begin
                r_out_year  <= '0;
                r_out_month <= '0;
                r_out_day   <= '0;
                r_out_after <= 1'b0;
            end
        end
    end

    assign o_end_year        = r_out_year;
    assign o_end_month       = r_out_month;
    assign o_end_day         = r_out_day;
    assign o_after_reference = r_out_after;
    assign o_status          = r_out_status;

endmodule

/* rtl/date_add_days.sv */
// top level of the gregorian date adder
// usage:
//   i_req carries a start date and a day count; ready is high only while idle,
//   and each request gives one result transfer on o_rsp: the advanced date,
//   a flag set when it lies strictly after the reference date, and a status
//   (ok, invalid start, year beyond 9999); date and flag are zero unless ok
//   the reference date is written on i_cfg_we / i_cfg_idx / i_cfg_data, index 0
//   year, 1 month, 2 day; the user writes only while idle; the block does not check
// sequence:
//   the transfer cycle loads, the year is reduced modulo 400 by restoring
//   subtraction, the start date is checked, then the walk steps one month at
//   a time up to the last partial month (no walk on an invalid start), and
//   the output register is filled; 65535 days cross up to about 2154 months;
//   ready returns as the result shows, so the block takes no new request
//   while one is still being worked on
// reset: synchronous, active low; clears the sequencer and output valid and
//   restores the reference date to 2023-06-13
// stall: a held result stays on o_rsp; the next request is still taken and
//   worked on, and waits for the output register to empty before it is shown
module date_add_days import dad_pkg::*; #(
    parameter int ADD_BITS = DAD_ADD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dad_in_if.sink                i_req,
    dad_out_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: owns the handshakes
    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: date registers, month step and result registers
    dad_dp #(
        .ADD_BITS (ADD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_start_year      (i_req.start_year),
        .i_start_month     (i_req.start_month),
        .i_start_day       (i_req.start_day),
        .i_days_to_add     (i_req.days_to_add),
        .o_end_year        (o_rsp.end_year),
        .o_end_month       (o_rsp.end_month),
        .o_end_day         (o_rsp.end_day),
        .o_after_reference (o_rsp.after_reference),
        .o_status          (o_rsp.status)
    );

endmodule

/* rtl/dad_checker.sv */
// port-level checks for the date adder and their bind
module dad_checker import dad_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [YEAR_W-1:0]   i_end_year,
    input logic [MONTH_W-1:0]  i_end_month,
    input logic [DAY_W-1:0]    i_end_day,
    input logic                i_after,
    input logic [STATUS_W-1:0] i_status
);

    // a held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after a transfer in
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // failed results carry no date
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK)
        |-> (i_end_year == '0) && (i_end_month == '0) && (i_end_day == '0) && !i_after)
        else $error("date fields set on failed result");

    // good results have a year 1..9999, a month 1..12 and a nonzero day
    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK)
        |-> (i_end_year != '0) && (i_end_year <= MAX_YEAR) && (i_end_month != '0)
            && (i_end_month <= LAST_MONTH) && (i_end_day != '0))
        else $error("ok result outside calendar");

    // no unused status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK) || (i_status == ST_INVALID)
                        || (i_status == ST_OVERFLOW))
        else $error("unknown status code");

endmodule

bind date_add_days dad_checker u_dad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_end_year  (o_rsp.end_year),
    .i_end_month (o_rsp.end_month),
    .i_end_day   (o_rsp.end_day),
    .i_after     (o_rsp.after_reference),
    .i_status    (o_rsp.status)
);

/* bench/tb_top.sv */
// self-checking bench for date_add_days: random and directed dates against a scoreboard
`timescale 1ns / 1ps

module tb_top;
    import dad_pkg::*;

    // one request and one result as the bench sees them
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DAYS_W-1:0]  days;
    } t_date_req;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               after_ref;
        t_status            status;
    } t_date_rsp;

    // holds the reference date, predicts each advanced date and checks results in order
    class date_scoreboard;
        t_date_rsp   advanced_q[$];
        int          errors;
        int unsigned ref_year;
        int unsigned ref_month;
        int unsigned ref_day;

        function new();
            errors    = 0;
            ref_year  = REF_YEAR_RST;
            ref_month = REF_MONTH_RST;
            ref_day   = REF_DAY_RST;
        endfunction

        static function bit is_leap(int unsigned y);
            return ((y % 4) == 0 && (y % CENTURY) != 0) || (y % LEAP_CYCLE) == 0;
        endfunction

        // month must be 1..12
        static function int unsigned month_length(int unsigned y, int unsigned m);
            case (m)
                2:       return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        function void set_reference(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REF_YEAR:  ref_year  = data[YEAR_W-1:0];
                REG_REF_MONTH: ref_month = data[MONTH_W-1:0];
                REG_REF_DAY:   ref_day   = data[DAY_W-1:0];
                default: ;
            endcase
        endfunction

        function t_date_rsp advance_date(t_date_req r);
            t_date_rsp   res;
            int unsigned y;
            int unsigned m;
            int unsigned d;
            int unsigned add;
            int unsigned left;
            bit          after;
            res = '0;
            y   = r.year;
            m   = r.month;
            d   = r.day;
            add = 32'(r.days) & ((32'd1 << DAD_ADD_BITS) - 1);
            if (y < 1 || y > MAX_YEAR || m < 1 || m > LAST_MONTH ||
                d < 1 || d > month_length(y, m)) begin
                res.status = ST_INVALID;
                return res;
            end
            // walk one month at a time, month lengths from the date being advanced
            while (add > 0) begin
                left = month_length(y, m) - d + 1;
                if (add < left) begin
                    d   = d + add;
                    add = 0;
                end else begin
                    add = add - left;
                    d   = 1;
                    if (m == LAST_MONTH) begin
                        if (y >= MAX_YEAR) begin
                            res.status = ST_OVERFLOW;
                            return res;
                        end
                        y = y + 1;
                        m = 1;
                    end else begin
                        m = m + 1;
                    end
                end
            end
            if (y != ref_year)
                after = y > ref_year;
            else if (m != ref_month)
                after = m > ref_month;
            else
                after = d > ref_day;
            res.year      = y[YEAR_W-1:0];
            res.month     = m[MONTH_W-1:0];
            res.day       = d[DAY_W-1:0];
            res.after_ref = after;
            res.status    = ST_OK;
            return res;
        endfunction

        function void note_request(t_date_req r);
            advanced_q.push_back(advance_date(r));
        endfunction

        function int pending();
            return advanced_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_date_rsp got);
            t_date_rsp want;
            if (advanced_q.size() == 0) begin
                report($sformatf("result %0d-%0d-%0d status %0d with nothing outstanding",
                                 got.year, got.month, got.day, got.status));
            end else begin
                want = advanced_q.pop_front();
                if (got.year != want.year)
                    report($sformatf("end_year got %0d expected %0d", got.year, want.year));
                if (got.month != want.month)
                    report($sformatf("end_month got %0d expected %0d", got.month, want.month));
                if (got.day != want.day)
                    report($sformatf("end_day got %0d expected %0d", got.day, want.day));
                if (got.after_ref != want.after_ref)
                    report($sformatf("after_reference got %0d expected %0d",
                                     got.after_ref, want.after_ref));
                if (got.status != want.status)
                    report($sformatf("status got %0d expected %0d", got.status, want.status));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dad_in_if  req_if();
    dad_out_if rsp_if();

    date_scoreboard sb = new();

    // idling switch shared by both sides, and the long receiver hold-off request
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    date_add_days dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard limit on the run, far above the slowest correct run
    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: ready changes at the falling edge; random stall bursts and one long hold
    initial begin : receiver
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // long hold so the block fills and stalls its input
                hold_left = 3000;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                rsp_if.ready <= 1'b0;
                gap_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 10) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // result monitor: sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result('{year:      rsp_if.end_year,
                              month:     rsp_if.end_month,
                              day:       rsp_if.end_day,
                              after_ref: rsp_if.after_reference,
                              status:    t_status'(rsp_if.status)});
    end

    // offer one request and hold it until the transfer
    task automatic send_request(t_date_req r);
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.start_year  <= r.year;
        req_if.start_month <= r.month;
        req_if.start_day   <= r.day;
        req_if.days_to_add <= r.days;
        @(posedge clk);
        while (!(req_if.valid && req_if.ready))
            @(posedge clk);
        sb.note_request(r);
        // sender side idling burst
        if (idle_on && $urandom_range(0, 3) == 0)
            req_pause($urandom_range(1, 10));
    endtask

    // drop valid and idle the sender for a pause whose length is set by n
    task automatic req_pause(int n);
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // one register write; the caller lowers the enable after the last one
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(data);
        @(posedge clk);
        sb.set_reference(idx, CFG_DATA_W'(data));
    endtask

    task automatic set_reference_date(int unsigned y, int unsigned m, int unsigned d);
        cfg_write(REG_REF_YEAR, y);
        cfg_write(REG_REF_MONTH, m);
        cfg_write(REG_REF_DAY, d);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every predicted date has come back
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic t_date_req random_request();
        t_date_req   r;
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        // pick the year first so the day fits its month
        if (pick >= 18 && pick < 26)
            r.year = YEAR_W'($urandom_range(9990, 9999));
        else if (pick >= 30 && pick < 55)
            r.year = YEAR_W'(CENTURY * $urandom_range(1, 99) + $urandom_range(0, 8) - 4);
        else
            r.year = YEAR_W'($urandom_range(1, 9999));
        r.month = MONTH_W'($urandom_range(1, 12));
        len     = date_scoreboard::month_length(r.year, r.month);
        r.day   = DAY_W'($urandom_range(1, len));
        if (pick < 12) begin
            // noise: any value of every field
            r.year  = YEAR_W'($urandom);
            r.month = MONTH_W'($urandom);
            r.day   = DAY_W'($urandom);
            r.days  = DAYS_W'($urandom);
        end else if (pick < 18) begin
            // broken start date
            r.days = DAYS_W'($urandom_range(0, 400));
            case ($urandom_range(0, 2))
                0: r.day   = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
                1: r.month = MONTH_W'($urandom_range(13, 16));
                default: r.year = ($urandom_range(0, 1) == 0) ? '0
                                  : YEAR_W'($urandom_range(10000, 16383));
            endcase
        end else if (pick < 26) begin
            // close to the end of year 9999
            r.days = DAYS_W'($urandom_range(0, 4000));
        end else if (pick < 30) begin
            // long walks, a few only
            r.days = DAYS_W'($urandom_range(30000, 65535));
        end else if (pick < 55) begin
            // around century years for the leap rule
            r.days = DAYS_W'($urandom_range(0, 1500));
        end else begin
            r.days = ($urandom_range(0, 1) == 0) ? DAYS_W'($urandom_range(0, 400))
                                                 : DAYS_W'($urandom_range(0, 3000));
        end
        return r;
    endfunction

    initial begin : stimulus
        t_date_req directed[$];
        t_date_req r;
        int unsigned len;
        req_if.valid       = 1'b0;
        req_if.start_year  = '0;
        req_if.start_month = '0;
        req_if.start_day   = '0;
        req_if.days_to_add = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part against the reset reference date
        directed.push_back('{14'd2023, 4'd6, 5'd13, 16'd0});     // equal to reference
        directed.push_back('{14'd2023, 4'd6, 5'd13, 16'd1});     // one day after
        directed.push_back('{14'd2023, 4'd6, 5'd12, 16'd0});     // one day before
        directed.push_back('{14'd1, 4'd1, 5'd1, 16'd0});         // earliest date
        directed.push_back('{14'd9999, 4'd12, 5'd31, 16'd0});    // latest date, zero days
        directed.push_back('{14'd9999, 4'd12, 5'd31, 16'd1});    // steps past 9999
        directed.push_back('{14'd9999, 4'd12, 5'd1, 16'd30});
        directed.push_back('{14'd9999, 4'd12, 5'd1, 16'd31});
        directed.push_back('{14'd9999, 4'd1, 5'd1, 16'hFFFF});   // overflow on a long count
        directed.push_back('{14'd1, 4'd1, 5'd1, 16'hFFFF});      // longest walk
        directed.push_back('{14'd2024, 4'd2, 5'd28, 16'd1});     // leap february
        directed.push_back('{14'd2023, 4'd2, 5'd28, 16'd1});
        directed.push_back('{14'd1900, 4'd2, 5'd28, 16'd1});     // century, not leap
        directed.push_back('{14'd2000, 4'd2, 5'd29, 16'd0});     // 400-year leap
        directed.push_back('{14'd1900, 4'd2, 5'd29, 16'd0});     // no feb 29
        directed.push_back('{14'd2023, 4'd4, 5'd31, 16'd5});     // day beyond month
        directed.push_back('{14'd0, 4'd1, 5'd1, 16'd5});         // year zero
        directed.push_back('{14'd10000, 4'd1, 5'd1, 16'd5});     // year too large
        directed.push_back('{14'h3FFF, 4'hF, 5'h1F, 16'hFFFF});  // all ones
        directed.push_back('{14'd2023, 4'd0, 5'd10, 16'd5});     // month zero
        directed.push_back('{14'd2023, 4'd13, 5'd10, 16'd5});    // month 13
        directed.push_back('{14'd2023, 4'd5, 5'd0, 16'd5});      // day zero
        directed.push_back('{14'd2023, 4'd1, 5'd31, 16'd1});     // month rollover
        directed.push_back('{14'd2023, 4'd12, 5'd31, 16'd1});    // year rollover
        foreach (directed[i])
            send_request(directed[i]);
        req_pause(1);

        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            case (phase)
                0: set_reference_date(9999, 12, 31);
                1: set_reference_date(0, 0, 0);
                2: set_reference_date(16383, 15, 31);
                3: set_reference_date(2000, 2, 29);
                default: set_reference_date($urandom_range(1, 9999), $urandom_range(1, 12),
                                            $urandom_range(1, 31));
            endcase
            // last part runs without any idling
            if (phase == 4)
                idle_on = 1'b0;
            if (phase == 1) begin
                // receiver holds off while short requests keep coming
                hold_req = 1'b1;
                repeat (10) begin
                    r.year  = YEAR_W'($urandom_range(1, 9999));
                    r.month = MONTH_W'($urandom_range(1, 12));
                    len     = date_scoreboard::month_length(r.year, r.month);
                    r.day   = DAY_W'($urandom_range(1, len));
                    r.days  = DAYS_W'($urandom_range(0, 60));
                    send_request(r);
                end
            end
            repeat (50)
                send_request(random_request());
            req_pause(1);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
